### hw/rtl/bafr_pkg.sv
// Shared types and codes for the best-fit bump allocator.
package bafr_pkg;

   localparam int unsigned DEFAULT_ENTRIES = 64;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NOT_INIT   = 3'd1;
   localparam logic [2:0] ST_TOO_LARGE  = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
   localparam logic [2:0] ST_TABLE_FULL = 3'd4;

   localparam logic CSR_HEAP_BASE = 1'b0;
   localparam logic CSR_HEAP_SIZE = 1'b1;

   typedef enum logic [1:0] {
      CMT_REUSE,
      CMT_NEW,
      CMT_FREE
   } commit_kind_type;

   typedef struct packed {
      logic        vld;
      logic        cmd;
      logic [31:0] size;
      logic [31:0] addr;
      logic        found;
      logic [31:0] len;
      logic [31:0] age;
      logic [31:0] start;
      logic        empty_found;
   } token_type;

   typedef struct packed {
      logic            en;
      commit_kind_type kind;
      logic [31:0]     start;
      logic [31:0]     length;
      logic [31:0]     stamp;
   } commit_type;

endpackage

### hw/rtl/bafr_cell.sv
// One table slot of the allocator and its stage of the search chain.
module bafr_cell #(
   parameter int unsigned IW  = 6,
   parameter int unsigned IDX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [31:0]          free_seq,
   input  bafr_pkg::token_type  tok_i,
   input  logic [IW-1:0]        best_idx_i,
   input  logic [IW-1:0]        empty_idx_i,
   output bafr_pkg::token_type  tok_o,
   output logic [IW-1:0]        best_idx_o,
   output logic [IW-1:0]        empty_idx_o,
   input  bafr_pkg::commit_type cmt,
   input  logic [IW-1:0]        cmt_idx
);

   localparam logic [IW-1:0] MY_IDX = IW'(IDX);

   logic        valid_ff, is_free_ff;
   logic [31:0] start_ff, length_ff, stamp_ff;
   bafr_pkg::token_type tok_ff, tok_in;
   logic [IW-1:0] best_idx_ff, best_idx_in, empty_idx_ff, empty_idx_in;
   logic [31:0] age;
   logic        take;

   always_comb begin
      tok_in       = tok_i;
      best_idx_in  = best_idx_i;
      empty_idx_in = empty_idx_i;
      age          = free_seq - stamp_ff;
      take         = 1'b0;
      if (tok_i.cmd == bafr_pkg::CMD_ALLOC) begin
         if (valid_ff && is_free_ff && length_ff >= tok_i.size) begin
            take = !tok_i.found || length_ff < tok_i.len ||
                   (length_ff == tok_i.len && age > tok_i.age);
         end
         if (!valid_ff && !tok_i.empty_found) begin
            tok_in.empty_found = 1'b1;
            empty_idx_in       = MY_IDX;
         end
      end else begin
         if (valid_ff && !is_free_ff && start_ff <= tok_i.addr) begin
            take = !tok_i.found || start_ff > tok_i.start;
         end
      end
      if (take) begin
         tok_in.found = 1'b1;
         tok_in.len   = length_ff;
         tok_in.age   = age;
         tok_in.start = start_ff;
         best_idx_in  = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff  <= best_idx_in;
      empty_idx_ff <= empty_idx_in;
      if (cmt.en && cmt_idx == MY_IDX) begin
         case (cmt.kind)
            bafr_pkg::CMT_NEW: begin
               start_ff  <= cmt.start;
               length_ff <= cmt.length;
               stamp_ff  <= cmt.stamp;
            end
            bafr_pkg::CMT_FREE: stamp_ff <= cmt.stamp;
            default: ;
         endcase
      end
      if (reset) begin
         tok_ff     <= '0;
         valid_ff   <= 1'b0;
         is_free_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in;
         if (cmt.en && cmt_idx == MY_IDX) begin
            case (cmt.kind)
               bafr_pkg::CMT_NEW: begin
                  valid_ff   <= 1'b1;
                  is_free_ff <= 1'b0;
               end
               bafr_pkg::CMT_REUSE: is_free_ff <= 1'b0;
               bafr_pkg::CMT_FREE:  is_free_ff <= 1'b1;
               default: ;
            endcase
         end
      end
   end

   assign tok_o       = tok_ff;
   assign best_idx_o  = best_idx_ff;
   assign empty_idx_o = empty_idx_ff;

endmodule

### hw/rtl/bump_allocator_with_best_fit_reuse.sv
// Top level of the best-fit bump allocator with its chain of slot cells.
//
// Requests arrive on the req_ channel as one word: a command (allocate or
// free), a size and an address. Each request yields exactly one rsp_ word
// holding a status code and, for a successful allocate, the block address.
// The user writes heap base and size on csr_ port only while idle; unchecked.
//
// A request is launched into a chain of TABLE_ENTRIES cells, one slot per
// cell; the search word moves one cell per cycle and carries the best
// candidate so far. It passes the launch register, the cells and the
// result register before the response is registered. The block takes one
// request at a time: the next is accepted once the previous one has left
// its final step.
//
// Reset clears all slot valid bits, the bump pointer and the free counter;
// slot contents need no clearing, so the block is ready in the cycle after
// reset. A response waits in its output register while the receiver stalls;
// the next request is still accepted and searched, but it holds in its final
// step, with the table unchanged, until the output register is free.
module bump_allocator_with_best_fit_reuse #(
   parameter int unsigned TABLE_ENTRIES = bafr_pkg::DEFAULT_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [31:0] req_req_size,
   input  logic [31:0] req_free_addr,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_block_addr,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wr_data
);

   localparam int unsigned IW = $clog2(TABLE_ENTRIES);

   typedef enum logic [1:0] {S_IDLE, S_LAUNCH, S_SCAN, S_FINISH} state_type;

   state_type   state_ff;
   logic [31:0] heap_base_ff, heap_size_ff, bytes_used_ff, free_seq_ff;
   logic        rsp_valid_ff;
   logic [2:0]  rsp_status_ff;
   logic [31:0] rsp_addr_ff;
   bafr_pkg::token_type launch_ff, launch_in, res_ff;
   logic [IW-1:0] best_ff, empty_ff;

   bafr_pkg::token_type tok [TABLE_ENTRIES+1];
   logic [IW-1:0] bidx [TABLE_ENTRIES+1];
   logic [IW-1:0] eidx [TABLE_ENTRIES+1];

   bafr_pkg::commit_type cmt;
   logic [IW-1:0] cmt_idx;
   logic [2:0]    status;
   logic [31:0]   addr, tail;
   logic          finish_go;

   assign tok[0]  = launch_ff;
   assign bidx[0] = '0;
   assign eidx[0] = '0;

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      bafr_cell #(.IW(IW), .IDX(g)) u_cell (
         .clock(clock), .reset(reset), .free_seq(free_seq_ff),
         .tok_i(tok[g]), .best_idx_i(bidx[g]), .empty_idx_i(eidx[g]),
         .tok_o(tok[g+1]), .best_idx_o(bidx[g+1]), .empty_idx_o(eidx[g+1]),
         .cmt(cmt), .cmt_idx(cmt_idx)
      );
   end

   assign finish_go = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      launch_in     = launch_ff;
      launch_in.vld = 1'b0;
      if (req_valid && req_ready) begin
         launch_in      = '0;
         launch_in.vld  = 1'b1;
         launch_in.cmd  = req_cmd;
         launch_in.size = req_req_size;
         launch_in.addr = req_free_addr;
      end
   end

   always_comb begin
      tail        = (bytes_used_ff <= heap_size_ff) ? heap_size_ff - bytes_used_ff : 32'd0;
      status      = bafr_pkg::ST_OK;
      addr        = 32'd0;
      cmt.en      = 1'b0;
      cmt.kind    = bafr_pkg::CMT_REUSE;
      cmt.start   = heap_base_ff + bytes_used_ff;
      cmt.length  = res_ff.size;
      cmt.stamp   = 32'd0;
      cmt_idx     = best_ff;
      if (res_ff.cmd == bafr_pkg::CMD_ALLOC) begin
         if (heap_base_ff == 32'd0) begin
            status = bafr_pkg::ST_NOT_INIT;
         end else if (res_ff.size > tail) begin
            status = bafr_pkg::ST_TOO_LARGE;
         end else if (res_ff.found) begin
            cmt.en = finish_go;
            addr   = res_ff.start;
         end else if (res_ff.empty_found) begin
            cmt.en   = finish_go;
            cmt.kind = bafr_pkg::CMT_NEW;
            cmt_idx  = empty_ff;
            addr     = cmt.start;
         end else begin
            status = bafr_pkg::ST_TABLE_FULL;
         end
      end else begin
         if (res_ff.found) begin
            cmt.en    = finish_go;
            cmt.kind  = bafr_pkg::CMT_FREE;
            cmt.stamp = free_seq_ff;
         end else begin
            status = bafr_pkg::ST_NOT_FOUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tok[TABLE_ENTRIES].vld) begin
         res_ff   <= tok[TABLE_ENTRIES];
         best_ff  <= bidx[TABLE_ENTRIES];
         empty_ff <= eidx[TABLE_ENTRIES];
      end
      if (finish_go) begin
         rsp_status_ff <= status;
         rsp_addr_ff   <= addr;
      end
      if (reset) begin
         state_ff      <= S_IDLE;
         launch_ff     <= '0;
         heap_base_ff  <= 32'd0;
         heap_size_ff  <= 32'd0;
         bytes_used_ff <= 32'd0;
         free_seq_ff   <= 32'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         launch_ff    <= launch_in;
         rsp_valid_ff <= finish_go || (rsp_valid_ff && !rsp_ready);
         if (csr_wr_en) begin
            unique case (csr_index)
               bafr_pkg::CSR_HEAP_BASE: heap_base_ff <= csr_wr_data;
               bafr_pkg::CSR_HEAP_SIZE: heap_size_ff <= csr_wr_data;
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_LAUNCH;
               end
            end
            S_LAUNCH: state_ff <= S_SCAN;
            S_SCAN: begin
               if (tok[TABLE_ENTRIES].vld) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (finish_go) begin
                  state_ff <= S_IDLE;
                  if (cmt.en && cmt.kind == bafr_pkg::CMT_NEW) begin
                     bytes_used_ff <= bytes_used_ff + res_ff.size;
                  end
                  if (cmt.en && cmt.kind == bafr_pkg::CMT_FREE) begin
                     free_seq_ff <= free_seq_ff + 32'd1;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready      = (state_ff == S_IDLE) && !reset;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_block_addr = rsp_addr_ff;

   a_addr_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bafr_pkg::ST_OK |-> rsp_block_addr == 32'd0)
      else $error("block address set on a failed request");

   a_used_only_on_finish: assert property (@(posedge clock) disable iff (reset)
      !$stable(bytes_used_ff) |-> $past(finish_go))
      else $error("bump pointer moved outside a commit");

   a_scan_out_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok[TABLE_ENTRIES].vld |-> state_ff == S_SCAN)
      else $error("search word left the chain outside a scan");

endmodule

### test/bump_allocator_with_best_fit_reuse_checker.sv
// Checker for the best-fit bump allocator: tracks the heap table and compares every response.
module bump_allocator_with_best_fit_reuse_checker #(
   parameter int unsigned TABLE_ENTRIES = bafr_pkg::DEFAULT_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_cmd,
   input  logic [31:0] req_req_size,
   input  logic [31:0] req_free_addr,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_status,
   input  logic [31:0] rsp_block_addr,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wr_data,
   output int          failures,
   output int          outstanding
);

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] block_addr;
   } heap_reply_type;

   heap_reply_type reply_queue[$];

   logic [31:0] heap_base_q;
   logic [31:0] heap_size_q;
   logic [31:0] bytes_used_q;
   logic [31:0] free_count_q;
   logic        slot_used_q  [TABLE_ENTRIES];
   logic        slot_freed_q [TABLE_ENTRIES];
   logic [31:0] slot_start_q [TABLE_ENTRIES];
   logic [31:0] slot_len_q   [TABLE_ENTRIES];
   logic [31:0] slot_stamp_q [TABLE_ENTRIES];

   assign outstanding = reply_queue.size();

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got 0x%08h expected 0x%08h", $realtime, what, got, want);
      failures++;
   endtask

   task automatic predict_alloc(input logic [31:0] size, output heap_reply_type r);
      logic [31:0] tail;
      int          best;
      int          empty;
      r = '{status: bafr_pkg::ST_OK, block_addr: '0};
      best = -1;
      empty = -1;
      if (heap_base_q == '0) begin
         r.status = bafr_pkg::ST_NOT_INIT;
         return;
      end
      tail = (bytes_used_q <= heap_size_q) ? heap_size_q - bytes_used_q : '0;
      if (size > tail) begin
         r.status = bafr_pkg::ST_TOO_LARGE;
         return;
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (!slot_used_q[i]) begin
            if (empty < 0) empty = i;
         end else if (slot_freed_q[i] && slot_len_q[i] >= size) begin
            if (best < 0 || slot_len_q[i] < slot_len_q[best]) begin
               best = i;
            end else if (slot_len_q[i] == slot_len_q[best] &&
                         32'(free_count_q - slot_stamp_q[i]) >
                         32'(free_count_q - slot_stamp_q[best])) begin
               best = i;
            end
         end
      end
      if (best >= 0) begin
         slot_freed_q[best] = 1'b0;
         r.block_addr = slot_start_q[best];
      end else if (empty < 0) begin
         r.status = bafr_pkg::ST_TABLE_FULL;
      end else begin
         slot_used_q[empty]  = 1'b1;
         slot_freed_q[empty] = 1'b0;
         slot_start_q[empty] = heap_base_q + bytes_used_q;
         slot_len_q[empty]   = size;
         slot_stamp_q[empty] = '0;
         r.block_addr = slot_start_q[empty];
         bytes_used_q = bytes_used_q + size;
      end
   endtask

   task automatic predict_free(input logic [31:0] addr, output heap_reply_type r);
      int best;
      r = '{status: bafr_pkg::ST_OK, block_addr: '0};
      best = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (slot_used_q[i] && !slot_freed_q[i] && slot_start_q[i] <= addr &&
             (best < 0 || slot_start_q[i] > slot_start_q[best])) best = i;
      end
      if (best < 0) begin
         r.status = bafr_pkg::ST_NOT_FOUND;
         return;
      end
      slot_freed_q[best] = 1'b1;
      slot_stamp_q[best] = free_count_q;
      free_count_q = free_count_q + 32'd1;
   endtask

   initial failures = 0;

   always @(posedge clock) begin
      heap_reply_type r;
      heap_reply_type want;
      if (reset) begin
         heap_base_q  = '0;
         heap_size_q  = '0;
         bytes_used_q = '0;
         free_count_q = '0;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            slot_used_q[i]  = 1'b0;
            slot_freed_q[i] = 1'b0;
         end
         reply_queue.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == bafr_pkg::CSR_HEAP_BASE) heap_base_q = csr_wr_data;
            else heap_size_q = csr_wr_data;
         end
         if (rsp_valid && rsp_ready) begin
            if (reply_queue.size() == 0) begin
               report_mismatch("unexpected word, status", 32'(rsp_status), '0);
            end else begin
               want = reply_queue.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
               if (rsp_block_addr !== want.block_addr)
                  report_mismatch("block_addr", rsp_block_addr, want.block_addr);
            end
         end
         if (req_valid && req_ready) begin
            if (req_cmd == bafr_pkg::CMD_ALLOC) predict_alloc(req_req_size, r);
            else predict_free(req_free_addr, r);
            reply_queue = {reply_queue, r};
         end
      end
   end

endmodule

### test/bump_allocator_with_best_fit_reuse_tb.sv
// Testbench top for the best-fit bump allocator: stimulus, flow control and verdict.
module bump_allocator_with_best_fit_reuse_tb;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_cmd;
   logic [31:0] req_req_size;
   logic [31:0] req_free_addr;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_block_addr;
   logic        csr_wr_en;
   logic        csr_index;
   logic [31:0] csr_wr_data;
   int          failures;
   int          outstanding;

   int          send_idle_pct;
   int          recv_stall_pct;
   int          hold_off_cycles;
   logic [31:0] granted_addrs[$];
   logic [31:0] base_now;

   bump_allocator_with_best_fit_reuse u_top (.*);

   bump_allocator_with_best_fit_reuse_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8000000;
      $display("Test completed with failures");
      $finish;
   end

   // The receiver stalls at random, and holds off completely while a hold-off is pending.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready && rsp_status == bafr_pkg::ST_OK &&
             rsp_block_addr != '0) begin
            granted_addrs = {granted_addrs, rsp_block_addr};
            if (granted_addrs.size() > 96) void'(granted_addrs.pop_front());
         end
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_off_cycles--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_word(input logic cmd, input logic [31:0] size, input logic [31:0] addr);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_req_size  <= size;
      req_free_addr <= addr;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_heap(input logic [31:0] base, input logic [31:0] size);
      csr_wr_en   <= 1'b1;
      csr_index   <= bafr_pkg::CSR_HEAP_BASE;
      csr_wr_data <= base;
      @(posedge clock);
      csr_index   <= bafr_pkg::CSR_HEAP_SIZE;
      csr_wr_data <= size;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
      base_now = base;
   endtask

   task automatic random_word;
      int          pick;
      logic [31:0] addr;
      pick = $urandom_range(99);
      if (pick < 55) begin
         send_word(bafr_pkg::CMD_ALLOC,
                   32'($urandom_range(0, 15) * 16 + $urandom_range(0, 3)), '0);
      end else if (pick < 60) begin
         send_word(bafr_pkg::CMD_ALLOC, $urandom, $urandom);
      end else if (pick < 93 && granted_addrs.size() > 0) begin
         addr = granted_addrs[$urandom_range(0, granted_addrs.size() - 1)];
         send_word(bafr_pkg::CMD_FREE, $urandom, addr + $urandom_range(0, 7));
      end else begin
         send_word(bafr_pkg::CMD_FREE, $urandom,
                   (pick & 1) ? $urandom : base_now + $urandom_range(0, 511));
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = bafr_pkg::CMD_ALLOC;
      req_req_size   = '0;
      req_free_addr  = '0;
      csr_wr_en      = 1'b0;
      csr_index      = bafr_pkg::CSR_HEAP_BASE;
      csr_wr_data    = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off_cycles = 0;
      base_now       = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: uninitialised heap, exact fit, zero length, tie on reuse, lookups.
      send_word(bafr_pkg::CMD_ALLOC, 32'd16, '0);
      send_word(bafr_pkg::CMD_FREE, '0, 32'hFFFF_FFFF);
      drain();
      write_heap(32'h0000_1000, 32'h0000_0100);
      send_word(bafr_pkg::CMD_ALLOC, 32'd0, '0);
      send_word(bafr_pkg::CMD_ALLOC, 32'd16, '0);
      send_word(bafr_pkg::CMD_ALLOC, 32'd16, '0);
      send_word(bafr_pkg::CMD_ALLOC, 32'd32, '0);
      send_word(bafr_pkg::CMD_FREE, '0, 32'h0000_0FFF);
      send_word(bafr_pkg::CMD_FREE, '0, 32'h0000_1010);
      send_word(bafr_pkg::CMD_FREE, '0, 32'h0000_1000);
      send_word(bafr_pkg::CMD_FREE, '0, 32'h0000_1000);
      send_word(bafr_pkg::CMD_ALLOC, 32'd16, '0);
      send_word(bafr_pkg::CMD_ALLOC, 32'd0, '0);
      send_word(bafr_pkg::CMD_ALLOC, 32'd200, '0);
      send_word(bafr_pkg::CMD_ALLOC, 32'hFFFF_FFFF, '0);
      send_word(bafr_pkg::CMD_ALLOC, 32'd192, '0);
      send_word(bafr_pkg::CMD_ALLOC, 32'd1, '0);
      send_word(bafr_pkg::CMD_FREE, '0, 32'hFFFF_FFFF);
      drain();
      write_heap(32'h0000_1000, 32'h0000_0010);
      send_word(bafr_pkg::CMD_ALLOC, 32'd0, '0);
      send_word(bafr_pkg::CMD_ALLOC, 32'd1, '0);
      drain();

      // Random part in phases of different settings and flow control.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_heap(32'h0001_0000, 32'h0010_0000);
            1: write_heap(32'hFFFF_F000, 32'hFFFF_FFFF);
            2: write_heap(32'h8000_0000, 32'h0000_0000);
            default: write_heap(32'h0000_0001, 32'hFFFF_FFFF);
         endcase
         send_idle_pct  = (phase == 1 || phase == 3) ? 57 : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? 57 : 0;
         if (phase == 3) begin
            send_idle_pct  = 14;
            recv_stall_pct = 14;
         end
         for (int n = 0; n < 120; n++) begin
            if (phase == 0 && n == 40) hold_off_cycles = 400;
            if (n == 80) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (outstanding != 0) @(posedge clock);
            end
            random_word();
         end
         drain();
      end

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/bafr_pkg.sv
hw/rtl/bafr_cell.sv
hw/rtl/bump_allocator_with_best_fit_reuse.sv
test/bump_allocator_with_best_fit_reuse_checker.sv
test/bump_allocator_with_best_fit_reuse_tb.sv
